// File: rtl/core/priority_ordered_task_list_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority-ordered task list
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_TASK_LIST_TOP_MACROS_SVH
`define PRIORITY_ORDERED_TASK_LIST_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define POTL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define POTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/potl_pkg.sv
// ----------------------------------------------------------------------------
// Priority-ordered task list package
// Sizes, request and status codes, and the transaction types shared by the
// front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package potl_pkg;

	localparam int DEPTH    = 32;
	localparam int TAG_BITS = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int COUNT_W  = 6;
	localparam int STATUS_W = 3;
	localparam int PRI_W    = 2;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

	localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADPRI   = 3'd4;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_INSERT_BAD,
		OP_READ,
		OP_REMOVE,
		OP_REMOVE_BAD,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_REMOVE,
		BK_REMOVE_END
	} back_state_t;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [TAG_BITS-1:0] task_tag;
		logic [PRI_W-1:0]    priority_req;
	} req_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] entry_tag;
		logic [PRI_W-1:0]    entry_priority;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
		logic                last;
	} rsp_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		op_t                 op;
		logic [TAG_BITS-1:0] tag;
		logic [PRI_W-1:0]    pri;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/potl_front.sv
// ----------------------------------------------------------------------------
// Priority-ordered task list front end
// Accepts request transactions, classifies them and queues them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module potl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire potl_pkg::req_t req,
	output logic               cmd_valid,
	output potl_pkg::cmd_t     cmd,
	input  wire logic          cmd_pop
);

	import potl_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       cls;

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	// A bad priority is only an error for insert and remove.
	always_comb begin
		cls.tag = req.task_tag;
		cls.pri = req.priority_req;
		case (req.req_type)
			REQ_INSERT: cls.op = (req.priority_req == PRI_NONE) ? OP_INSERT_BAD : OP_INSERT;
			REQ_READ:   cls.op = OP_READ;
			REQ_REMOVE: cls.op = (req.priority_req == PRI_NONE) ? OP_REMOVE_BAD : OP_REMOVE;
			REQ_CLEAR:  cls.op = OP_CLEAR;
			default:    cls.op = OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/potl_back.sv
// ----------------------------------------------------------------------------
// Priority-ordered task list back end
// Holds the sorted entry store, runs the request sequencer and drives the
// response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module potl_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire potl_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output potl_pkg::rsp_t      rsp
);

	import potl_pkg::*;

	logic [TAG_BITS-1:0] tag_mem [DEPTH];
	logic [PRI_W-1:0]    pri_mem [DEPTH];

	back_state_t         state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]    wr_cnt_q, wr_cnt_d;
	logic [PRI_W-1:0]    rm_pri_q, rm_pri_d;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                can_emit;
	logic                emit;
	rsp_t                emit_rsp;
	logic                ins_en;
	logic                rm_wr_en;
	logic [DEPTH-1:0]    ge;
	logic [TAG_BITS-1:0] rd_tag;
	logic [PRI_W-1:0]    rd_pri;
	logic                rd_last;
	logic [CNT_W-1:0]    removed;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign can_emit  = !rsp_valid_q || !rsp_stall;
	assign rd_tag    = tag_mem[rd_idx_q];
	assign rd_pri    = pri_mem[rd_idx_q];
	assign rd_last   = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;
	assign removed   = count_q - wr_cnt_q;

	// Cell i is at or past the insert point when it is unused or holds a
	// lower priority than the new entry. The store is sorted, so this is a
	// suffix of the cells.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CNT_W'(i) >= count_q) || (pri_mem[i] > cmd.pri);
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rd_idx_d = rd_idx_q;
		wr_cnt_d = wr_cnt_q;
		rm_pri_d = rm_pri_q;
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		ins_en   = 1'b0;
		rm_wr_en = 1'b0;
		emit_rsp.last = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && can_emit) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_INSERT_BAD: begin
							emit = 1'b1;
							emit_rsp.entry_count = COUNT_W'(count_q);
							emit_rsp.status      = ST_BADPRI;
						end
						OP_INSERT: begin
							emit = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								emit_rsp.entry_count = COUNT_W'(count_q);
								emit_rsp.status      = ST_FULL;
							end else begin
								ins_en  = 1'b1;
								count_d = count_q + CNT_W'(1);
								emit_rsp.entry_count = COUNT_W'(count_d);
								emit_rsp.status      = ST_OK;
							end
						end
						OP_READ: begin
							if (count_q == '0) begin
								emit = 1'b1;
								emit_rsp.status = ST_EMPTY;
							end else begin
								rd_idx_d = '0;
								state_d  = BK_READ;
							end
						end
						OP_REMOVE_BAD: begin
							emit = 1'b1;
							if (count_q == '0) begin
								emit_rsp.status = ST_EMPTY;
							end else begin
								emit_rsp.entry_count = COUNT_W'(count_q);
								emit_rsp.status      = ST_BADPRI;
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								emit = 1'b1;
								emit_rsp.status = ST_EMPTY;
							end else begin
								rd_idx_d = '0;
								wr_cnt_d = '0;
								rm_pri_d = cmd.pri;
								state_d  = BK_REMOVE;
							end
						end
						OP_CLEAR: begin
							emit = 1'b1;
							if (count_q == '0) begin
								emit_rsp.status = ST_EMPTY;
							end else begin
								count_d = '0;
								emit_rsp.status = ST_OK;
							end
						end
						default: begin
							emit = 1'b1;
							emit_rsp.status = ST_EMPTY;
						end
					endcase
				end
			end
			BK_READ: begin
				if (can_emit) begin
					emit = 1'b1;
					emit_rsp.entry_tag      = rd_tag;
					emit_rsp.entry_priority = rd_pri;
					emit_rsp.entry_count    = COUNT_W'(count_q);
					emit_rsp.status         = ST_OK;
					emit_rsp.last           = rd_last;
					rd_idx_d = rd_idx_q + IDX_W'(1);
					if (rd_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_REMOVE: begin
				// Compact in place: survivors move down to the write index.
				if (rd_pri != rm_pri_q) begin
					rm_wr_en = 1'b1;
					wr_cnt_d = wr_cnt_q + CNT_W'(1);
				end
				rd_idx_d = rd_idx_q + IDX_W'(1);
				if (rd_last) begin
					state_d = BK_REMOVE_END;
				end
			end
			BK_REMOVE_END: begin
				if (can_emit) begin
					emit = 1'b1;
					emit_rsp.entry_count = COUNT_W'(removed);
					emit_rsp.status      = (removed != '0) ? ST_OK : ST_NOTFOUND;
					count_d = wr_cnt_q;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_idx_d;
		wr_cnt_q <= wr_cnt_d;
		rm_pri_q <= rm_pri_d;
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	// Each cell either keeps its value, takes the new entry, takes its lower
	// neighbor during an insert, or takes a survivor during a remove pass.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ins_en) begin
				if (g == 0) begin
					if (ge[0]) begin
						tag_mem[0] <= cmd.tag;
						pri_mem[0] <= cmd.pri;
					end
				end else if (ge[g] && !ge[(g == 0) ? 0 : g - 1]) begin
					tag_mem[g] <= cmd.tag;
					pri_mem[g] <= cmd.pri;
				end else if (ge[(g == 0) ? 0 : g - 1]) begin
					tag_mem[g] <= tag_mem[(g == 0) ? 0 : g - 1];
					pri_mem[g] <= pri_mem[(g == 0) ? 0 : g - 1];
				end
			end else if (rm_wr_en && (wr_cnt_q[IDX_W-1:0] == IDX_W'(g))) begin
				tag_mem[g] <= rd_tag;
				pri_mem[g] <= rd_pri;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/priority_ordered_task_list_top.sv
// ----------------------------------------------------------------------------
// Priority-ordered task list, top level
// Sorted store of up to DEPTH tagged tasks with insert, read-out, remove by
// priority and clear requests.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH entries (a task tag and a priority from 1 high
// to 3 low) in ascending priority, with equal priorities in arrival order.
// Each request transaction on the req channel produces exactly one response
// transaction on the rsp channel, except a read-out of a non-empty store,
// which produces one response per entry in order with last set on the final
// one. Requests pass through a two-entry command queue, so up to two more
// requests are taken while a long one is still being carried out; req_stall
// rises only when that queue is full. In the back end an insert, a clear, and
// any request that fails on taking its command (a bad priority, a full or an
// empty store) are carried out and answered as the command is taken, since
// the insert shifts every entry behind the insert point in one step. A
// read-out takes the command and then sends the held entries one at a time,
// as the single read port of the entry store allows. A remove takes the
// command, walks the store once, one entry per cycle, and then reports. The
// response sits in an output register that is refilled in the cycle it is
// taken, so a stalled rsp channel holds the back end but not the front end.
// The store needs no clearing after reset: only entries below the held count
// are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_ordered_task_list_top_macros.svh"

module priority_ordered_task_list_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire potl_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output potl_pkg::rsp_t      rsp
);

	import potl_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// Front end: accept and classify requests, queue them as commands.
	potl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: the sorted store, the request sequencer and the output register.
	potl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// The back end only takes a command that the queue actually holds.
	`POTL_ASSERT_SAME(a_pop_needs_cmd, cmd_pop, cmd_valid, "command popped from empty queue")

	// Every error status ends its request with a single response.
	`POTL_ASSERT_SAME(a_error_is_last, rsp_valid && (rsp.status != ST_OK), rsp.last,
		"error response without last")

	// Only read-out entries carry a priority, so any other response is final.
	`POTL_ASSERT_SAME(a_plain_is_last, rsp_valid && (rsp.entry_priority == PRI_NONE), rsp.last,
		"non-entry response without last")

	// Entries of one read-out leave in ascending priority.
	`POTL_ASSERT_NEXT(a_readout_sorted,
		rsp_valid && !rsp_stall && !rsp.last && (rsp.entry_priority != PRI_NONE),
		!rsp_valid || (rsp.entry_priority >= $past(rsp.entry_priority)),
		"read-out entries out of priority order")

endmodule

`default_nettype wire
